[rtl/core/pem_pkg.sv]
// Shared types and constants for the Prewitt edge magnitude unit.
`timescale 1ns / 1ps

package pem_pkg;

   localparam int PIXEL_W            = 8;
   localparam int ABS_W              = PIXEL_W + 2;      // |Gx|, |Gy| and three-pixel sums
   localparam int SQ_SUM_W           = 2 * ABS_W + 1;    // Gx^2 + Gy^2
   localparam int ROOT_W             = PIXEL_W;
   localparam int ROOT_IN_W          = 2 * ROOT_W;       // sums at or above this width saturate
   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;
   localparam int MIN_DIM            = 3;
   localparam int DIM_REG_W          = 11;
   localparam int CSR_DATA_W         = 32;
   localparam int CSR_ADDR_W         = 3;

   localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RESET = 11'd1024;

   localparam logic [ROOT_W-1:0] MAG_SAT    = 8'd255;
   localparam logic [ROOT_W-1:0] MAG_BORDER = 8'd0;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_ROOT,
      S_OUT
   } state_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [ROOT_W-1:0] root;
   } root_status_type;

endpackage

[rtl/core/pem_ram.sv]
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module pem_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/pem_root.sv]
// Saturating integer square root of Gx^2 + Gy^2, one result bit per cycle.
`timescale 1ns / 1ps

module pem_root (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pem_pkg::ABS_W-1:0]     abs_x,
   input  logic [pem_pkg::ABS_W-1:0]     abs_y,
   output pem_pkg::root_status_type      status
);

   localparam logic [3:0] CNT_SQUARE = 4'd0;
   localparam logic [3:0] CNT_LAST   = 4'd8;

   logic [pem_pkg::ABS_W-1:0]     ax_ff, ay_ff;
   logic [pem_pkg::ROOT_IN_W-1:0] sum_ff;
   logic                          sat_ff;
   logic [pem_pkg::ROOT_W-1:0]    root_ff;
   logic [3:0]                    cnt_ff;
   logic                          busy_ff, done_ff;

   logic [pem_pkg::SQ_SUM_W-1:0]  sq_sum;
   logic [2:0]                    bit_idx;
   logic [pem_pkg::ROOT_W-1:0]    trial;
   logic [pem_pkg::ROOT_IN_W-1:0] trial_sq;

   always_comb begin
      sq_sum   = pem_pkg::SQ_SUM_W'(ax_ff) * pem_pkg::SQ_SUM_W'(ax_ff)
               + pem_pkg::SQ_SUM_W'(ay_ff) * pem_pkg::SQ_SUM_W'(ay_ff);
      bit_idx  = 3'(CNT_LAST - cnt_ff);
      trial    = root_ff | (pem_pkg::ROOT_W'(1) << bit_idx);
      trial_sq = pem_pkg::ROOT_IN_W'(trial) * pem_pkg::ROOT_IN_W'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_SQUARE;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_SQUARE;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ax_ff   <= abs_x;
         ay_ff   <= abs_y;
         root_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_SQUARE) begin
            sum_ff <= sq_sum[pem_pkg::ROOT_IN_W-1:0];
            sat_ff <= (sq_sum[pem_pkg::SQ_SUM_W-1:pem_pkg::ROOT_IN_W] != '0);
         end else if (trial_sq <= sum_ff) begin
            root_ff <= trial;
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign status.root = sat_ff ? pem_pkg::MAG_SAT : root_ff;

endmodule

[rtl/core/prewitt_edge_magnitude_unit.sv]
// Top level of the streaming 3x3 Prewitt edge magnitude unit.
`timescale 1ns / 1ps
//
//  channel  direction  handshake                 payload
//  req      in         req_tvalid/req_tready     tdata = pixel, tuser = op (0 pixel, 1 drain)
//  rsp      out        rsp_tvalid/rsp_tready     tdata = magnitude, tlast = frame_last
//  csr      in         APB, pready always high   0x0 frame_width, 0x4 frame_height
//
//  A request is taken in S_IDLE and handled in S_FETCH; an interior pixel then runs S_ROOT
//  (a squaring step and the eight-step root iteration) and a result goes to S_OUT, else the
//  unit returns to S_IDLE. The line-store read is registered ahead of the window update.
//  Reset clears the counters; the line store has no clearing pass and its data reach a
//  result only where it was written earlier in the frame.
//  One result register: a request is taken while a result waits, and the next result
//  holds until rsp_tready frees the register.

module prewitt_edge_magnitude_unit #(
   parameter int MAX_WIDTH  = pem_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = pem_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pem_pkg::PIXEL_W-1:0]       req_tdata,   // [7:0] pixel
   input  logic                              req_tuser,   // [0] op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pem_pkg::PIXEL_W-1:0]       rsp_tdata,   // [7:0] magnitude
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pem_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pem_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pem_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WD     = $clog2(MAX_WIDTH + 1);
   localparam int HD     = $clog2(MAX_HEIGHT + 1);
   localparam int TOT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int CLW    = (WD > pem_pkg::DIM_REG_W) ? WD : pem_pkg::DIM_REG_W;
   localparam int CLH    = (HD > pem_pkg::DIM_REG_W) ? HD : pem_pkg::DIM_REG_W;
   localparam int PW     = pem_pkg::PIXEL_W;
   localparam int AW     = pem_pkg::ABS_W;
   localparam int LINE_W = 2 * PW;

   // configuration
   logic [pem_pkg::DIM_REG_W-1:0] width_ff, height_ff;
   logic                          csr_write;
   pem_pkg::csr_index_type        csr_index;
   logic [CLW-1:0]                width_ext;
   logic [CLH-1:0]                height_ext;
   logic [WD-1:0]                 w_clamp, w_ff;
   logic [HD-1:0]                 h_clamp, h_ff;
   logic [TOT_W-1:0]              total_in, tail_in, lastpos_in;
   logic [TOT_W-1:0]              tail_ff, lastpos_ff;

   // frame state
   pem_pkg::state_type            state_ff, state_in;
   logic [COL_W-1:0]              col_ff, col_in;
   logic [ROW_W-1:0]              row_ff, row_in;
   logic [TOT_W-1:0]              pos_ff, pos_in;
   logic [PW-1:0]                 win_ff [6];
   logic [PW-1:0]                 win_in [6];
   pem_pkg::op_type               op_ff;
   logic [PW-1:0]                 pix_ff;
   logic [PW-1:0]                 mag_ff, mag_in;
   logic                          last_ff, last_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                 rsp_data_ff, rsp_data_in;
   logic                          rsp_last_ff, rsp_last_in;

   // datapath
   logic                          req_accept;
   logic                          ram_we;
   logic [LINE_W-1:0]             ram_rdata;
   logic [PW-1:0]                 top_px, mid_px;
   logic [AW-1:0]                 sum_left, sum_right, sum_up, sum_down;
   logic signed [AW:0]            gx, gy;
   logic [AW-1:0]                 ax, ay;
   logic                          emit, interior, col_wrap, row_wrap;
   logic                          root_start;
   pem_pkg::root_status_type      root_status;

   // ---------------- configuration port ----------------
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = pem_pkg::csr_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_index)
         pem_pkg::CSR_FRAME_WIDTH:  csr_prdata = pem_pkg::CSR_DATA_W'(width_ff);
         pem_pkg::CSR_FRAME_HEIGHT: csr_prdata = pem_pkg::CSR_DATA_W'(height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pem_pkg::FRAME_WIDTH_RESET;
         height_ff <= pem_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            pem_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_pwdata[pem_pkg::DIM_REG_W-1:0];
            pem_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_pwdata[pem_pkg::DIM_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_ext  = CLW'(width_ff);
      height_ext = CLH'(height_ff);
      if (width_ext < CLW'(pem_pkg::MIN_DIM))   w_clamp = WD'(pem_pkg::MIN_DIM);
      else if (width_ext > CLW'(MAX_WIDTH))     w_clamp = WD'(MAX_WIDTH);
      else                                      w_clamp = WD'(width_ext);
      if (height_ext < CLH'(pem_pkg::MIN_DIM))  h_clamp = HD'(pem_pkg::MIN_DIM);
      else if (height_ext > CLH'(MAX_HEIGHT))   h_clamp = HD'(MAX_HEIGHT);
      else                                      h_clamp = HD'(height_ext);
      total_in   = TOT_W'(TOT_W'(w_clamp) * TOT_W'(h_clamp));
      tail_in    = total_in - TOT_W'(w_clamp) - TOT_W'(1);
      lastpos_in = total_in - TOT_W'(1);
   end

   // frame geometry is a registered copy of the clamped registers
   always_ff @(posedge clock) begin
      w_ff       <= w_clamp;
      h_ff       <= h_clamp;
      tail_ff    <= tail_in;
      lastpos_ff <= lastpos_in;
   end

   // ---------------- line store ----------------
   // entry c holds {middle row, top row} for column c
   pem_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (col_ff),
      .wr_data ({pix_ff, mid_px}),
      .rd_addr (col_ff),
      .rd_data (ram_rdata)
   );

   // ---------------- gradient ----------------
   always_comb begin
      top_px    = ram_rdata[PW-1:0];
      mid_px    = ram_rdata[LINE_W-1:PW];
      sum_left  = AW'(win_ff[0]) + AW'(win_ff[1]) + AW'(win_ff[2]);
      sum_right = AW'(top_px) + AW'(mid_px) + AW'(pix_ff);
      sum_up    = AW'(win_ff[0]) + AW'(win_ff[3]) + AW'(top_px);
      sum_down  = AW'(win_ff[2]) + AW'(win_ff[5]) + AW'(pix_ff);
      gx        = $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
      gy        = $signed({1'b0, sum_up}) - $signed({1'b0, sum_down});
      ax        = gx[AW] ? AW'(-gx) : AW'(gx);
      ay        = gy[AW] ? AW'(-gy) : AW'(gy);
      // output lags input by one row and one column; interior needs two of each
      emit      = (row_ff >= ROW_W'(2)) || ((row_ff == ROW_W'(1)) && (col_ff != '0));
      interior  = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
      col_wrap  = (WD'(col_ff) + WD'(1)) == w_ff;
      row_wrap  = (HD'(row_ff) + HD'(1)) == h_ff;
   end

   pem_root u_root (
      .clock  (clock),
      .reset  (reset),
      .start  (root_start),
      .abs_x  (ax),
      .abs_y  (ay),
      .status (root_status)
   );

   // ---------------- control ----------------
   assign req_tready = (state_ff == pem_pkg::S_IDLE);
   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pos_in       = pos_ff;
      win_in       = win_ff;
      mag_in       = mag_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      root_start   = 1'b0;

      case (state_ff)
         pem_pkg::S_IDLE: begin
            if (req_accept) begin
               state_in = pem_pkg::S_FETCH;
            end
         end

         pem_pkg::S_FETCH: begin
            state_in = pem_pkg::S_IDLE;
            if (op_ff == pem_pkg::OP_DRAIN) begin
               if (pos_ff >= tail_ff) begin
                  mag_in   = pem_pkg::MAG_BORDER;
                  last_in  = (pos_ff >= lastpos_ff);
                  state_in = pem_pkg::S_OUT;
                  if (pos_ff >= lastpos_ff) begin
                     col_in = '0;
                     row_in = '0;
                     pos_in = '0;
                  end else begin
                     pos_in = pos_ff + TOT_W'(1);
                  end
               end
            end else if (pos_ff < tail_ff) begin
               // pixels arriving once the frame is all in are dropped
               ram_we    = 1'b1;
               win_in[0] = win_ff[3];
               win_in[1] = win_ff[4];
               win_in[2] = win_ff[5];
               win_in[3] = top_px;
               win_in[4] = mid_px;
               win_in[5] = pix_ff;
               if (col_wrap) begin
                  col_in = '0;
                  row_in = row_wrap ? '0 : row_ff + ROW_W'(1);
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
               last_in = 1'b0;
               if (emit) begin
                  pos_in = pos_ff + TOT_W'(1);
                  if (interior) begin
                     root_start = 1'b1;
                     state_in   = pem_pkg::S_ROOT;
                  end else begin
                     mag_in   = pem_pkg::MAG_BORDER;
                     state_in = pem_pkg::S_OUT;
                  end
               end
            end
         end

         pem_pkg::S_ROOT: begin
            if (root_status.done) begin
               mag_in   = root_status.root;
               state_in = pem_pkg::S_OUT;
            end
         end

         pem_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mag_ff;
               rsp_last_in  = last_ff;
               state_in     = pem_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = pem_pkg::S_IDLE;
         end
      endcase

      // a register write abandons the frame in progress
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pem_pkg::S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      mag_ff      <= mag_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (req_accept) begin
         op_ff  <= pem_pkg::op_type'(req_tuser);
         pix_ff <= req_tdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   a_ram_write_pixel: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == pem_pkg::S_FETCH) && (op_ff == pem_pkg::OP_PIXEL))
      else $error("line store written outside a pixel fetch");

   a_root_done_in_root: assert property (@(posedge clock) disable iff (reset)
      root_status.done |-> (state_ff == pem_pkg::S_ROOT))
      else $error("root result arrived with no root pending");

   a_root_waits_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pem_pkg::S_ROOT) |-> (root_status.busy || root_status.done))
      else $error("waiting on a root unit that is idle");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == pem_pkg::S_OUT))
      else $error("result loaded outside the output state");
`endif

endmodule
